FILE: src/udm64_pkg.sv
// ----------------------------------------------------------------------------
// udm64_pkg - shared types for the 64-bit unsigned divider
// Holds the field width and the structs passed along the cell row.
// ----------------------------------------------------------------------------
package udm64_pkg;

  // Width of each operand and result field on the stream ports
  localparam int unsigned FIELD_W = 64;

  // Bits handed from one cell to its upper neighbour every cycle
  typedef struct packed {
    logic rem;     // remainder bit, shifted up one place per step
    logic quo;     // dividend / quotient bit, shifted up one place per step
    logic borrow;  // borrow of the trial subtraction
  } link_t;

  // Controls broadcast to every cell
  typedef struct packed {
    logic load;    // capture operands, clear remainder
    logic run;     // perform one restoring step
    logic take;    // trial subtraction succeeded: keep the difference
  } ctrl_t;

endpackage

FILE: src/udm64_cell.sv
// ----------------------------------------------------------------------------
// udm64_cell - one bit slice of the restoring divider
// Holds one remainder bit, one dividend/quotient bit and one divisor bit, and
// forms its bit of the trial subtraction from the borrow of the cell below.
// ----------------------------------------------------------------------------
module udm64_cell
  import udm64_pkg::*;
(
  input  logic  clk_i,
  input  ctrl_t ctrl_i,
  input  link_t link_i,
  input  logic  num_i,
  input  logic  den_i,
  output link_t link_o,
  output logic  rem_o,
  output logic  quo_o
);

  logic r_q, r_d;
  logic q_q, q_d;
  logic d_q, d_d;
  logic diff;

  // Bit of (shifted remainder - divisor)
  assign diff          = link_i.rem ^ d_q ^ link_i.borrow;
  assign link_o.borrow = (~link_i.rem & d_q) | (~(link_i.rem ^ d_q) & link_i.borrow);
  assign link_o.rem    = r_q;
  assign link_o.quo    = q_q;

  // Next state: load operands, or shift and conditionally keep the difference
  always_comb begin
    r_d = r_q;
    q_d = q_q;
    d_d = d_q;
    if (ctrl_i.load) begin
      r_d = 1'b0;
      q_d = num_i;
      d_d = den_i;
    end else if (ctrl_i.run) begin
      r_d = ctrl_i.take ? diff : link_i.rem;
      q_d = link_i.quo;
    end
  end

  // Payload only, no reset needed
  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    q_q <= q_d;
    d_q <= d_d;
  end

  assign rem_o = r_q;
  assign quo_o = q_q;

endmodule

FILE: src/unsigned_divmod_64_unit.sv
// ----------------------------------------------------------------------------
// unsigned_divmod_64_unit - 64-bit unsigned divider with remainder
// Radix-2 restoring divider built as a row of DATA_WIDTH bit-slice cells.
// ----------------------------------------------------------------------------
// One item at a time: a new input is taken only in the idle state, after the
// previous result has moved to the output register. In the run state it forms
// one quotient bit per cycle from the borrow chain running through the cell row.
// The result register lets a new item start while a result waits.
// Reset (rst_ni low, asynchronous) empties the unit; no results are pending.
// ----------------------------------------------------------------------------
module unsigned_divmod_64_unit
  import udm64_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [63:0] dividend, [127:64] divisor
  input  logic [2*FIELD_W-1:0] s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [63:0] quotient, [127:64] remainder
  output logic [2*FIELD_W-1:0] m_axis_tdata_o,
  // [0] divide_by_zero
  output logic                 m_axis_tuser_o
);

  localparam int unsigned CntW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   cnt_q;
  logic              dbz_q;
  logic              out_valid_q;
  logic [FIELD_W-1:0] quo_out_q, rem_out_q;
  logic              tuser_q;

  ctrl_t                  ctrl;
  link_t                  chain [DATA_WIDTH+1];
  logic [DATA_WIDTH-1:0]  num, den, rem_w, quo_w;
  logic                   in_xfer, out_free;

  assign num      = s_axis_tdata_i[DATA_WIDTH-1:0];
  assign den      = s_axis_tdata_i[FIELD_W +: DATA_WIDTH];
  assign in_xfer  = s_axis_tvalid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || m_axis_tready_i;

  // Broadcast controls; take when the shifted-out bit is set or no borrow
  assign ctrl.load = in_xfer;
  assign ctrl.run  = (state_q == ST_RUN);
  assign ctrl.take = chain[DATA_WIDTH].rem | ~chain[DATA_WIDTH].borrow;

  // Lowest cell gets the dividend MSB as remainder input, new quotient bit in
  assign chain[0].rem    = chain[DATA_WIDTH].quo;
  assign chain[0].quo    = ctrl.take;
  assign chain[0].borrow = 1'b0;

  // Row of bit-slice cells
  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    udm64_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .link_i (chain[i]),
      .num_i  (num[i]),
      .den_i  (den[i]),
      .link_o (chain[i+1]),
      .rem_o  (rem_w[i]),
      .quo_o  (quo_w[i])
    );
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      dbz_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // New result loaded, or the waiting one leaves
      if ((state_q == ST_HOLD) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_RUN;
            cnt_q   <= CntW'(DATA_WIDTH - 1);
            dbz_q   <= (den == '0);
          end
        end
        ST_RUN: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Result payload; zero divisor forces both fields to zero
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_HOLD) && out_free) begin
      quo_out_q <= dbz_q ? '0 : FIELD_W'(quo_w);
      rem_out_q <= dbz_q ? '0 : FIELD_W'(rem_w);
      tuser_q   <= dbz_q;
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {rem_out_q, quo_out_q};
  assign m_axis_tuser_o  = tuser_q;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for unsigned_divmod_64_unit
// Streams dividend/divisor pairs into the divider with random gaps on both
// sides, predicts quotient, remainder and the divide-by-zero flag for every
// input transfer and checks each result transfer against the oldest one.
// ----------------------------------------------------------------------------
module testbench;
  import udm64_pkg::*;

  localparam int unsigned OPER_W      = 64;
  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic [FIELD_W-1:0] OPER_MASK = {FIELD_W{1'b1}} >> (FIELD_W - OPER_W);

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;
    logic               div_by_zero;
  } divmod_result_t;

  // Holds the predicted results in transfer order and checks the outputs
  class divmod_scoreboard;
    divmod_result_t awaited[$];
    int unsigned    mismatches = 0;

    function divmod_result_t divide_operands(logic [FIELD_W-1:0] dividend,
                                             logic [FIELD_W-1:0] divisor);
      divmod_result_t res;
      logic [FIELD_W-1:0] num;
      logic [FIELD_W-1:0] den;
      num = dividend & OPER_MASK;
      den = divisor & OPER_MASK;
      if (den == '0) begin
        res.quotient    = '0;
        res.remainder   = '0;
        res.div_by_zero = 1'b1;
      end else begin
        res.quotient    = (num / den) & OPER_MASK;
        res.remainder   = (num % den) & OPER_MASK;
        res.div_by_zero = 1'b0;
      end
      return res;
    endfunction

    function void note_operands(logic [FIELD_W-1:0] dividend, logic [FIELD_W-1:0] divisor);
      awaited.push_back(divide_operands(dividend, divisor));
    endfunction

    function void check_result(logic [FIELD_W-1:0] quotient, logic [FIELD_W-1:0] remainder,
                               logic div_by_zero);
      divmod_result_t exp_res;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: q=%h r=%h dbz=%b", quotient, remainder, div_by_zero);
        return;
      end
      exp_res = awaited.pop_front();
      if (exp_res.quotient !== quotient || exp_res.remainder !== remainder ||
          exp_res.div_by_zero !== div_by_zero) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected q=%h r=%h dbz=%b, got q=%h r=%h dbz=%b",
                   exp_res.quotient, exp_res.remainder, exp_res.div_by_zero,
                   quotient, remainder, div_by_zero);
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [2*FIELD_W-1:0] s_axis_tdata_i;   // [63:0] dividend, [127:64] divisor
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [2*FIELD_W-1:0] m_axis_tdata_o;   // [63:0] quotient, [127:64] remainder
  logic                 m_axis_tuser_o;   // [0] divide_by_zero

  divmod_scoreboard sb;
  bit               no_idle;
  int unsigned      cycle_count;

  unsigned_divmod_64_unit #(
    .DATA_WIDTH(OPER_W)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // Clock, 10 ns period
  always #5 clk_i = ~clk_i;

  function automatic int unsigned draw_gap();
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [FIELD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // One input transfer after a random gap; inputs change on the falling edge
  task automatic send_operands(logic [FIELD_W-1:0] dividend, logic [FIELD_W-1:0] divisor);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {divisor, dividend};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_operands(dividend, divisor);
  endtask

  // Operand pairs drawn from several classes to reach all quotient shapes
  task automatic send_random();
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;
    dividend = rand_word();
    divisor  = rand_word();
    case ($urandom_range(0, 9))
      0: ;
      1: divisor = '0;
      2: divisor = FIELD_W'($urandom_range(1, 255));
      3: divisor = FIELD_W'(1) << $urandom_range(0, FIELD_W - 1);
      4: begin
        if (divisor == '0) divisor = 1;
        dividend = dividend % divisor;
      end
      5: begin
        dividend = FIELD_W'($urandom);
        divisor  = FIELD_W'($urandom);
      end
      6: divisor = divisor >> $urandom_range(0, FIELD_W - 1);
      7: begin
        case ($urandom_range(0, 2))
          0: dividend = divisor;
          1: dividend = divisor - 1;
          default: dividend = divisor + 1;
        endcase
      end
      default: begin
        dividend = dividend >> $urandom_range(0, FIELD_W - 1);
        divisor  = divisor >> $urandom_range(0, FIELD_W - 1);
      end
    endcase
    send_operands(dividend, divisor);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls, check every output transfer
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        @(negedge clk_i);
        m_axis_tready_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_result(m_axis_tdata_o[FIELD_W-1:0], m_axis_tdata_o[2*FIELD_W-1:FIELD_W],
                      m_axis_tuser_o);
    end
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Reset, directed cases, random phases, drain
  initial begin
    logic [FIELD_W-1:0] all_ones;
    sb              = new();
    all_ones        = '1;
    no_idle         = 1'b0;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero divisor
    send_operands('0, '0);
    send_operands(all_ones, '0);
    send_operands(64'h0123_4567_89ab_cdef, '0);
    // Small and power-of-two divisors
    send_operands(all_ones, 64'd1);
    send_operands(all_ones, 64'd2);
    send_operands(64'hdead_beef_cafe_f00d, 64'd16);
    send_operands(64'hdead_beef_cafe_f00d, 64'd32);
    send_operands(64'hdead_beef_cafe_f00d, 64'd4096);
    // Extremes
    send_operands(all_ones, all_ones);
    send_operands('0, all_ones);
    send_operands('0, 64'd1);
    send_operands(all_ones, 64'h8000_0000_0000_0000);
    send_operands(64'h8000_0000_0000_0000, all_ones);
    send_operands(all_ones, 64'd3);
    send_operands(all_ones, all_ones - 1);
    // Dividend below divisor
    send_operands(64'd5, 64'd7);
    send_operands(all_ones - 1, all_ones);
    // Operands around the 32-bit boundary
    send_operands(64'hffff_ffff, 64'h0001_0001);
    send_operands(64'h8765_4321, 64'hffff_ffff);
    send_operands(64'h1_0000_0000, 64'hffff_ffff);
    // Alternating bit patterns
    send_operands(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555);
    send_operands(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaab);

    for (int phase = 0; phase < 4; phase++) begin
      no_idle = (phase == 1);
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_random();
      // Hold the input side until the divider has emptied once
      if (phase == 1) begin
        @(negedge clk_i);
        s_axis_tvalid_i <= 1'b0;
        wait_drained();
      end
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    wait_drained();
    repeat (OPER_W + 10) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
